[src/assert_macros.svh]
// assertion macros used by the checker file
// each macro clocks on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define LZWD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lzwd assertion failed");

// antecedent in one cycle, consequent in the next
`define LZWD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lzwd assertion failed");

`endif

[src/lzwd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared types, codes and constants of the variable-width code decoder.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  // default dictionary size
  localparam int unsigned DICT_ENTRIES_DEF = 4096;

  // special codes and dictionary restart values
  localparam int unsigned CODE_CLEAR  = 32'h100;
  localparam int unsigned CODE_END    = 32'h101;
  localparam int unsigned FIRST_FREE  = 258;
  localparam int unsigned START_WIDTH = 9;

  // length register width
  localparam int unsigned LEN_W = 24;

  // transaction function codes
  localparam logic FUNC_FEED = 1'b0;
  localparam logic FUNC_PULL = 1'b1;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_REFUSED = 2'd1;
  localparam logic [1:0] STAT_FIN     = 2'd2;
  localparam logic [1:0] STAT_ERR     = 2'd3;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
  } lzwd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [1:0] status;
    logic       is_last;
  } lzwd_out_t;

  // build one result item
  function automatic lzwd_out_t mk_res(logic [7:0] b, logic v, logic [1:0] s, logic l);
    lzwd_out_t r;
    r.out_byte  = b;
    r.out_valid = v;
    r.status    = s;
    r.is_last   = l;
    return r;
  endfunction

endpackage

[src/lzwd_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lzwd_pkg::DICT_ENTRIES_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/lzwd_unpack.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_unpack
// Bit accumulator: collects compressed bytes and cuts codes MSB-first.
// ----------------------------------------------------------------------------
module lzwd_unpack #(
  parameter int unsigned DICT_ENTRIES = lzwd_pkg::DICT_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(DICT_ENTRIES),
  localparam int unsigned CW = AW + 1,
  localparam int unsigned WW = $clog2(CW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    in_byte_i,
  input  logic [WW-1:0] cw_i,
  input  logic          load_i,
  output logic          code_ok_o,
  output logic [CW-1:0] code_o
);

  localparam int unsigned BUF_W  = 24;
  localparam int unsigned HELD_W = 5;

  logic [BUF_W-1:0]  buf_q, buf_d;
  logic [HELD_W-1:0] held_q, held_d;
  logic [BUF_W-1:0]  shifted;
  logic [BUF_W-1:0]  code_mask;
  logic [BUF_W-1:0]  rem_mask;
  logic [HELD_W-1:0] held_sum;
  logic [HELD_W-1:0] cw_ext;
  logic [HELD_W-1:0] rem;

  // append the byte and cut one code when enough bits are held
  always_comb begin
    shifted   = {buf_q[BUF_W-9:0], in_byte_i};
    held_sum  = held_q + HELD_W'(8);
    cw_ext    = HELD_W'(cw_i);
    code_ok_o = (held_sum >= cw_ext);
    rem       = held_sum - cw_ext;
    code_mask = (BUF_W'(1) << cw_i) - BUF_W'(1);
    rem_mask  = (BUF_W'(1) << rem) - BUF_W'(1);
    code_o    = CW'((shifted >> rem) & code_mask);
    buf_d     = buf_q;
    held_d    = held_q;
    if (load_i) begin
      if (code_ok_o) begin
        buf_d  = shifted & rem_mask;
        held_d = rem;
      end else begin
        buf_d  = shifted;
        held_d = held_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      held_q <= '0;
    end else begin
      buf_q  <= buf_d;
      held_q <= held_d;
    end
  end

endmodule

[src/lzwd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Sequencer around the dictionary and expansion stack memories: adds
// entries, walks prefix chains onto the stack and pops decoded bytes.
// ----------------------------------------------------------------------------
module lzwd_ctrl #(
  parameter int unsigned DICT_ENTRIES = lzwd_pkg::DICT_ENTRIES_DEF,
  localparam int unsigned AW = $clog2(DICT_ENTRIES),
  localparam int unsigned CW = AW + 1,
  localparam int unsigned WW = $clog2(CW + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lzwd_pkg::lzwd_in_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lzwd_pkg::lzwd_out_t       out_data_o,
  input  logic [lzwd_pkg::LEN_W-1:0] out_len_i,
  input  logic                      code_ok_i,
  input  logic [CW-1:0]             code_i,
  output logic [WW-1:0]             cw_o,
  output logic                      load_o
);

  import lzwd_pkg::*;

  localparam int unsigned DW = AW + 8;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_POP} st_e;

  st_e              state_q, state_d;
  logic [CW-1:0]    dict_q, dict_d;
  logic [WW-1:0]    cw_q, cw_d;
  logic [CW-1:0]    prev_q, prev_d;
  logic             prev_ok_q, prev_ok_d;
  logic [7:0]       prev_lead_q, prev_lead_d;
  logic [CW-1:0]    sp_q, sp_d;
  logic [LEN_W-1:0] bytes_q, bytes_d;
  logic             fin_q, fin_d;
  logic             err_q, err_d;
  logic [CW-1:0]    walk_q, walk_d;
  logic [CW-1:0]    code_q, code_d;
  logic             add_q, add_d;
  logic [AW-1:0]    add_idx_q, add_idx_d;
  logic             lt_q, lt_d;
  lzwd_out_t        res_q, res_d;
  logic             res_vld_q, res_vld_d;

  // memory ports
  logic             dict_we;
  logic [DW-1:0]    dict_wdata;
  logic [AW-1:0]    dict_raddr;
  logic [DW-1:0]    dict_rdata;
  logic             stk_we;
  logic [AW-1:0]    stk_waddr;
  logic [7:0]       stk_wdata;
  logic [7:0]       stk_rdata;

  logic             accept;
  logic             can_add;
  logic             bad_code;
  logic             grow;
  logic [CW:0]      dict_inc;
  logic [CW-1:0]    sp_dec;
  logic [CW-1:0]    walk_start;
  logic [AW-1:0]    rd_prefix;
  logic [7:0]       rd_last;
  logic [LEN_W-1:0] bytes_inc;

  // dictionary word: prefix code and last character
  lzwd_ram #(
    .WIDTH (DW),
    .DEPTH (DICT_ENTRIES)
  ) u_dict_ram (
    .clk_i   (clk_i),
    .we_i    (dict_we),
    .waddr_i (add_idx_q),
    .wdata_i (dict_wdata),
    .raddr_i (dict_raddr),
    .rdata_o (dict_rdata)
  );

  // expansion stack, popped from the top by pulls
  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (DICT_ENTRIES)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (sp_dec[AW-1:0]),
    .rdata_o (stk_rdata)
  );

  // decode helpers
  always_comb begin
    rd_prefix  = dict_rdata[DW-1:8];
    rd_last    = dict_rdata[7:0];
    sp_dec     = sp_q - CW'(1);
    bytes_inc  = bytes_q + LEN_W'(1);
    can_add    = prev_ok_q && (dict_q != CW'(DICT_ENTRIES));
    bad_code   = (code_i > dict_q) || ((code_i == dict_q) && !can_add);
    dict_inc   = {1'b0, dict_q} + (CW+1)'(1);
    grow       = ((dict_inc + (CW+1)'(1)) & dict_inc) == '0;
    walk_start = (can_add && (code_i == dict_q)) ? prev_q : code_i;
    dict_raddr = (state_q == ST_WALK) ? rd_prefix : walk_start[AW-1:0];
    in_stall_o = !((state_q == ST_IDLE) && (!res_vld_q || !out_stall_i));
    accept     = in_valid_i && !in_stall_o;
  end

  // next state and memory control
  always_comb begin
    state_d     = state_q;
    dict_d      = dict_q;
    cw_d        = cw_q;
    prev_d      = prev_q;
    prev_ok_d   = prev_ok_q;
    prev_lead_d = prev_lead_q;
    sp_d        = sp_q;
    bytes_d     = bytes_q;
    fin_d       = fin_q;
    err_d       = err_q;
    walk_d      = walk_q;
    code_d      = code_q;
    add_d       = add_q;
    add_idx_d   = add_idx_q;
    lt_d        = lt_q;
    res_d       = res_q;
    res_vld_d   = res_vld_q && out_stall_i;
    load_o      = 1'b0;
    dict_we     = 1'b0;
    dict_wdata  = {prev_q[AW-1:0], (lt_q ? walk_q[7:0] : prev_lead_q)};
    stk_we      = 1'b0;
    stk_waddr   = sp_q[AW-1:0];
    stk_wdata   = rd_last;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (err_q) begin
            res_d     = mk_res(8'h00, 1'b0, STAT_ERR, 1'b0);
            res_vld_d = 1'b1;
          end else begin
            unique case (in_data_i.func)
              FUNC_FEED: begin
                if (sp_q != '0) begin
                  res_d     = mk_res(8'h00, 1'b0, STAT_REFUSED, 1'b0);
                  res_vld_d = 1'b1;
                end else if (fin_q || (bytes_q >= out_len_i)) begin
                  fin_d     = 1'b1;
                  res_d     = mk_res(8'h00, 1'b0, STAT_FIN, 1'b0);
                  res_vld_d = 1'b1;
                end else begin
                  load_o = 1'b1;
                  if (!code_ok_i) begin
                    res_d     = mk_res(8'h00, 1'b0, STAT_OK, 1'b0);
                    res_vld_d = 1'b1;
                  end else if (code_i == CW'(CODE_END)) begin
                    fin_d     = 1'b1;
                    res_d     = mk_res(8'h00, 1'b0, STAT_FIN, 1'b0);
                    res_vld_d = 1'b1;
                  end else if (bad_code) begin
                    err_d     = 1'b1;
                    res_d     = mk_res(8'h00, 1'b0, STAT_ERR, 1'b0);
                    res_vld_d = 1'b1;
                  end else if (code_i == CW'(CODE_CLEAR)) begin
                    dict_d    = CW'(FIRST_FREE);
                    cw_d      = WW'(START_WIDTH);
                    prev_ok_d = 1'b0;
                    res_d     = mk_res(8'h00, 1'b0, STAT_OK, 1'b0);
                    res_vld_d = 1'b1;
                  end else begin
                    // start a chain walk, entry added when it ends
                    add_d     = can_add;
                    add_idx_d = dict_q[AW-1:0];
                    lt_d      = code_i < dict_q;
                    code_d    = code_i;
                    if (can_add) begin
                      dict_d = dict_inc[CW-1:0];
                      if (grow) begin
                        cw_d = cw_q + WW'(1);
                      end
                    end
                    if (can_add && (code_i == dict_q)) begin
                      // code names the entry being added
                      stk_we    = 1'b1;
                      stk_waddr = '0;
                      stk_wdata = prev_lead_q;
                      sp_d      = CW'(1);
                      walk_d    = prev_q;
                    end else begin
                      sp_d   = '0;
                      walk_d = code_i;
                    end
                    state_d = ST_WALK;
                  end
                end
              end
              FUNC_PULL: begin
                if (sp_q != '0) begin
                  sp_d    = sp_dec;
                  state_d = ST_POP;
                end else begin
                  res_d     = mk_res(8'h00, 1'b0, fin_q ? STAT_FIN : STAT_OK, 1'b0);
                  res_vld_d = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end

      ST_WALK: begin
        stk_we = 1'b1;
        sp_d   = sp_q + CW'(1);
        if (walk_q >= CW'(FIRST_FREE)) begin
          // push the entry's last character and follow its prefix
          stk_wdata = rd_last;
          walk_d    = {1'b0, rd_prefix};
        end else begin
          // chain root: push it and finish the code
          stk_wdata   = walk_q[7:0];
          prev_lead_d = walk_q[7:0];
          dict_we     = add_q;
          prev_d      = code_q;
          prev_ok_d   = 1'b1;
          res_d       = mk_res(8'h00, 1'b0, STAT_OK, 1'b0);
          res_vld_d   = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      ST_POP: begin
        bytes_d = bytes_inc;
        if (bytes_inc == out_len_i) begin
          fin_d = 1'b1;
          sp_d  = '0;
          res_d = mk_res(stk_rdata, 1'b1, STAT_FIN, 1'b1);
        end else begin
          res_d = mk_res(stk_rdata, 1'b1, fin_q ? STAT_FIN : STAT_OK, 1'b0);
        end
        res_vld_d = 1'b1;
        state_d   = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dict_q      <= CW'(FIRST_FREE);
      cw_q        <= WW'(START_WIDTH);
      prev_q      <= '0;
      prev_ok_q   <= 1'b0;
      prev_lead_q <= '0;
      sp_q        <= '0;
      bytes_q     <= '0;
      fin_q       <= 1'b0;
      err_q       <= 1'b0;
      walk_q      <= '0;
      code_q      <= '0;
      add_q       <= 1'b0;
      add_idx_q   <= '0;
      lt_q        <= 1'b0;
      res_q       <= '0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      dict_q      <= dict_d;
      cw_q        <= cw_d;
      prev_q      <= prev_d;
      prev_ok_q   <= prev_ok_d;
      prev_lead_q <= prev_lead_d;
      sp_q        <= sp_d;
      bytes_q     <= bytes_d;
      fin_q       <= fin_d;
      err_q       <= err_d;
      walk_q      <= walk_d;
      code_q      <= code_d;
      add_q       <= add_d;
      add_idx_q   <= add_idx_d;
      lt_q        <= lt_d;
      res_q       <= res_d;
      res_vld_q   <= res_vld_d;
    end
  end

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;
  assign cw_o        = cw_q;

endmodule

[src/lzw_decompressor_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzw_decompressor_top
// Variable-width (9 bits and up) code decoder with byte feed and byte pull.
// ----------------------------------------------------------------------------
// Each transaction on the input channel is a feed of one compressed byte or a
// pull of one decoded byte, and gives exactly one result transaction. Feeds,
// refused feeds, empty pulls and clear or end codes are answered straight
// from the idle state. A pull that delivers a byte passes through a pop state
// for the registered read of the expansion stack memory. A feed that completes
// a code pushes each byte of the decoded string onto the stack (the last byte
// is pushed before the walk when the code names the entry being added), since
// the prefix chain is walked through the dictionary memory at one read per
// cycle. The dictionary needs no clearing pass after reset. The output length
// register is written over the config channel while the block is idle: this
// binds the user, and the block itself does not enforce it.
module lzw_decompressor_top #(
  parameter int unsigned DICT_ENTRIES = lzwd_pkg::DICT_ENTRIES_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  lzwd_pkg::lzwd_in_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output lzwd_pkg::lzwd_out_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [lzwd_pkg::LEN_W-1:0] cfg_data_i
);

  import lzwd_pkg::*;

  localparam int unsigned AW = $clog2(DICT_ENTRIES);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned WW = $clog2(CW + 1);

  logic [LEN_W-1:0] out_len_q;
  logic             code_ok;
  logic [CW-1:0]    code;
  logic [WW-1:0]    cw;
  logic             load;

  // output length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      out_len_q <= cfg_data_i;
    end
  end

  // code extraction
  lzwd_unpack #(
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_unpack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_byte_i (in_data_i.in_byte),
    .cw_i      (cw),
    .load_i    (load),
    .code_ok_o (code_ok),
    .code_o    (code)
  );

  // dictionary and stack sequencer
  lzwd_ctrl #(
    .DICT_ENTRIES (DICT_ENTRIES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .out_len_i   (out_len_q),
    .code_ok_i   (code_ok),
    .code_i      (code),
    .cw_o        (cw),
    .load_o      (load)
  );

endmodule

[src/lzwd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzwd_checker
// Port-level checks on the result channel of the decoder top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzwd_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  lzwd_pkg::lzwd_out_t out_data_i
);

  import lzwd_pkg::*;

  // a stalled result stays offered and unchanged
  `LZWD_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i)
  `LZWD_ASSERT_NEXT(a_out_stable, out_valid_i && out_stall_i, $stable(out_data_i))

  // the final byte is a delivered byte and reports the stream finished
  `LZWD_ASSERT(a_last_fin, (out_valid_i && out_data_i.is_last) |-> (out_data_i.out_valid && out_data_i.status == STAT_FIN))

  // no byte, no last flag, zero data
  `LZWD_ASSERT(a_empty_zero, (out_valid_i && !out_data_i.out_valid) |-> (out_data_i.out_byte == 8'h00 && !out_data_i.is_last))

endmodule

bind lzw_decompressor_top lzwd_checker u_lzwd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
